FILE: design/sos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Set-of-stacks package
// Opcodes, status codes, register indexes and the flag bundle shared by the
// stack engine and its count unit.
// -----------------------------------------------------------------------------
package sos_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_POP_AT = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADIDX = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_IN_USE   = 1'b1;

   // Field widths fixed by the interface.
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned INDEX_W    = 3;
   localparam int unsigned CAP_CFG_W  = 5;
   localparam int unsigned USE_CFG_W  = 4;

   localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd10;
   localparam logic [USE_CFG_W-1:0] USE_RESET = 4'd5;

   // Flags from the shared count unit to the sequencer.
   typedef struct packed {
      logic below_cap;
      logic empty;
   } sos_flags_type;

endpackage
`default_nettype wire

FILE: design/set_of_stacks_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Set-of-stacks engine
// A bank of fixed-capacity stacks with a current-stack pointer, served by a
// small sequencer around one fill-count unit and a value memory.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single response
// appears on the rsp_ ports for one cycle with rsp_valid high and cannot be
// held off. A push reads the fill count of the current stack and, if it is
// full, of the next one; a pop reads the count of each stack it walks back
// over, then the value from the first that is not empty. A no-op, a push
// with the pointer beyond the stacks in use and a pop-at with a bad index
// are answered from idle. Timing is set by the fill-count memory, read once
// per cycle with a registered output, and by the registered read of the value
// memory. While a transaction is in flight busy is high; the next request may
// be taken in the cycle its response is shown. Configuration writes are
// accepted at any time but must only be issued while the engine is idle.
// -----------------------------------------------------------------------------
module set_of_stacks_engine_top
   import sos_pkg::*;
#(
   parameter int unsigned NUM_STACKS  = 8,
   parameter int unsigned STACK_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [VALUE_W-1:0]   req_push_value,
   input  wire logic [INDEX_W-1:0]   req_stack_index,
   // Response channel
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [VALUE_W-1:0]        rsp_popped_value,
   output logic [INDEX_W-1:0]        rsp_current_stack_out,
   // Configuration channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [CAP_CFG_W-1:0] csr_wdata
);

   localparam int unsigned PW  = $clog2(NUM_STACKS);
   localparam int unsigned OW  = $clog2(STACK_DEPTH);
   localparam int unsigned NW  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW  = $clog2(NUM_STACKS * STACK_DEPTH);
   localparam int unsigned IW  = ((PW > 3) ? PW : 3) + 2;
   localparam int unsigned MW  = ((NW > CAP_CFG_W) ? NW : CAP_CFG_W) + 1;
   localparam int unsigned NUM_WORDS = NUM_STACKS * STACK_DEPTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_CHECK_NEXT,
      S_READ_VALUE
   } state_type;

   // Configuration registers.
   logic [CAP_CFG_W-1:0] cap_cfg_ff;
   logic [USE_CFG_W-1:0] use_cfg_ff;

   // Sequencer state.
   state_type            state_ff, state_in;
   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [PW-1:0]        work_ff, work_in;
   logic [PW-1:0]        cur_ff, cur_in;

   // Response registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_popped_ff, rsp_popped_in;
   logic [INDEX_W-1:0]   rsp_cur_ff, rsp_cur_in;

   // Fill-count memory with per-stack valid bits; an invalid entry reads zero.
   logic [NW-1:0]        cnt_mem [NUM_STACKS];
   logic [NUM_STACKS-1:0] cnt_vld_ff;
   logic [NW-1:0]        cnt_q_ff;
   logic                 cnt_vq_ff;
   logic                 cnt_we;
   logic [NW-1:0]        cnt_wdata;
   logic [NW-1:0]        cnt_cur;

   // Value memory.
   logic [VALUE_W-1:0]   val_mem [NUM_WORDS];
   logic [VALUE_W-1:0]   val_q_ff;
   logic                 val_we;
   logic [OW-1:0]        val_off;
   logic [AW-1:0]        val_addr;

   // Derived configuration and count unit signals.
   logic [MW-1:0]        cap_eff;
   logic [IW-1:0]        use_eff;
   logic [IW-1:0]        cur_ext;
   logic [IW-1:0]        idx_ext;
   logic [IW-1:0]        work_ext;
   sos_flags_type        flags;
   logic [NW-1:0]        cnt_inc;
   logic [NW-1:0]        cnt_dec;
   logic                 accept;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_popped_value      = rsp_popped_ff;
   assign rsp_current_stack_out = rsp_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_cfg_ff <= CAP_RESET;
         use_cfg_ff <= USE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_cfg_ff <= csr_wdata;
            CSR_IN_USE:   use_cfg_ff <= csr_wdata[USE_CFG_W-1:0];
            default:      ;
         endcase
      end
   end

   // Capacity clamped to 1..STACK_DEPTH, stacks in use to 1..NUM_STACKS.
   always_comb begin
      if (cap_cfg_ff == '0) begin
         cap_eff = MW'(1);
      end else if (MW'(cap_cfg_ff) > MW'(STACK_DEPTH)) begin
         cap_eff = MW'(STACK_DEPTH);
      end else begin
         cap_eff = MW'(cap_cfg_ff);
      end
      if (use_cfg_ff == '0) begin
         use_eff = IW'(1);
      end else if (IW'(use_cfg_ff) > IW'(NUM_STACKS)) begin
         use_eff = IW'(NUM_STACKS);
      end else begin
         use_eff = IW'(use_cfg_ff);
      end
   end

   assign cur_ext  = IW'(cur_ff);
   assign idx_ext  = IW'(req_stack_index);
   assign work_ext = IW'(work_ff);
   assign cnt_cur  = cnt_vq_ff ? cnt_q_ff : '0;

   sos_cnt_unit #(
      .NW (NW),
      .MW (MW)
   ) u_cnt_unit (
      .count     (cnt_cur),
      .cap       (cap_eff),
      .flags     (flags),
      .count_inc (cnt_inc),
      .count_dec (cnt_dec)
   );

   assign val_addr = AW'(work_ff) * AW'(STACK_DEPTH) + AW'(val_off);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      work_in       = work_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_cur_in    = rsp_cur_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = cnt_inc;
      val_we        = 1'b0;
      val_off       = cnt_cur[OW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_opcode;
               val_in        = req_push_value;
               work_in       = cur_ff;
               rsp_popped_in = '0;
               rsp_cur_in    = cur_ext[INDEX_W-1:0];
               unique case (req_opcode)
                  OP_PUSH: begin
                     if (cur_ext >= use_eff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  OP_POP: begin
                     state_in = S_CHECK;
                  end
                  OP_POP_AT: begin
                     if (idx_ext >= use_eff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BADIDX;
                     end else begin
                        work_in  = idx_ext[PW-1:0];
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_CHECK, S_CHECK_NEXT: begin
            if (op_ff == OP_PUSH) begin
               if (flags.below_cap) begin
                  val_we        = 1'b1;
                  cnt_we        = 1'b1;
                  cur_in        = work_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_cur_in    = work_ext[INDEX_W-1:0];
                  state_in      = S_IDLE;
               end else if (state_ff == S_CHECK && (work_ext + IW'(1)) < use_eff) begin
                  // Current stack is full; try the next one.
                  work_in  = PW'(work_ext + IW'(1));
                  state_in = S_CHECK_NEXT;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end
            end else begin
               if (flags.empty) begin
                  if (op_ff == OP_POP && work_ff != '0) begin
                     // Walk back past an empty stack and look again.
                     work_in = work_ff - PW'(1);
                  end else begin
                     if (op_ff == OP_POP) begin
                        cur_in     = work_ff;
                        rsp_cur_in = work_ext[INDEX_W-1:0];
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     state_in      = S_IDLE;
                  end
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_dec;
                  val_off   = cnt_dec[OW-1:0];
                  if (op_ff == OP_POP) begin
                     cur_in     = work_ff;
                     rsp_cur_in = work_ext[INDEX_W-1:0];
                  end
                  state_in = S_READ_VALUE;
               end
            end
         end

         S_READ_VALUE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_popped_in = val_q_ff;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      work_ff       <= work_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_cur_ff    <= rsp_cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (cnt_we) begin
         cnt_vld_ff[work_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[work_ff] <= cnt_wdata;
      end
      cnt_q_ff  <= cnt_mem[work_in];
      cnt_vq_ff <= cnt_vld_ff[work_in];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_addr] <= val_ff;
      end
      val_q_ff <= val_mem[val_addr];
   end

`ifndef NO_ASSERTIONS
   // A response only follows a cycle in which a transaction was in flight
   // or a request was taken.
   a_rsp_has_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("response without a transaction");

   // Every accepted request is either answered at once or keeps the engine busy.
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted request dropped");

   // Only a successful pop returns a nonzero value.
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_popped_value == '0))
      else $error("failed operation returned a value");

   // The working stack index stays inside the bank while in flight.
   a_work_range : assert property (@(posedge clock) disable iff (reset)
      busy |-> (work_ext < IW'(NUM_STACKS)))
      else $error("working stack index out of range");
`endif

endmodule
`default_nettype wire

FILE: design/sos_cnt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Set-of-stacks count unit
// Shared arithmetic on one stack fill count: compare against the capacity,
// test for empty, and form the incremented and decremented counts.
// -----------------------------------------------------------------------------
module sos_cnt_unit
   import sos_pkg::*;
#(
   parameter int unsigned NW = 5,
   parameter int unsigned MW = 6
) (
   input  wire logic [NW-1:0] count,
   input  wire logic [MW-1:0] cap,
   output sos_flags_type      flags,
   output logic [NW-1:0]      count_inc,
   output logic [NW-1:0]      count_dec
);

   always_comb begin
      flags.below_cap = (MW'(count) < cap);
      flags.empty     = (count == '0);
      count_inc       = count + NW'(1);
      count_dec       = count - NW'(1);
   end

endmodule
`default_nettype wire

FILE: test/set_of_stacks_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Set-of-stacks checker
// Watches the request, response and register channels of the stack engine.
// It keeps its own model of the stack bank and queues the response that each
// accepted request should produce. Every response is compared field by field
// with the oldest queued one.
// -----------------------------------------------------------------------------
module set_of_stacks_checker
   import sos_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [VALUE_W-1:0]   req_push_value,
   input  wire logic [INDEX_W-1:0]   req_stack_index,
   input  wire logic                 rsp_valid,
   input  wire logic [STATUS_W-1:0]  rsp_status,
   input  wire logic [VALUE_W-1:0]   rsp_popped_value,
   input  wire logic [INDEX_W-1:0]   rsp_current_stack_out,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [CAP_CFG_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        reqs_taken,
   output int                        csr_taken
);

   localparam int unsigned N_STACKS = 8;
   localparam int unsigned DEPTH    = 16;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  popped;
      logic [INDEX_W-1:0]  cur;
   } stack_result_type;

   logic [VALUE_W-1:0]   value_mem [N_STACKS][DEPTH];
   int unsigned          fill [N_STACKS];
   int unsigned          ptr_stack;
   logic [CAP_CFG_W-1:0] cap_cfg;
   logic [USE_CFG_W-1:0] use_cfg;
   stack_result_type     stack_results_q[$];

   // Applies one operation to the model bank and returns its response.
   function automatic stack_result_type predict_stack_op(input logic [OPCODE_W-1:0] op,
                                                         input logic [VALUE_W-1:0]  val,
                                                         input logic [INDEX_W-1:0]  idx);
      int unsigned      cap_eff;
      int unsigned      used;
      int unsigned      s;
      stack_result_type r;
      cap_eff  = (cap_cfg == '0) ? 1 : ((cap_cfg > DEPTH) ? DEPTH : cap_cfg);
      used     = (use_cfg == '0) ? 1 : ((use_cfg > N_STACKS) ? N_STACKS : use_cfg);
      r.status = ST_OK;
      r.popped = '0;
      s        = ptr_stack;
      case (op)
         OP_PUSH: begin
            if (s >= used) begin
               r.status = ST_FULL;
            end else if (fill[s] < cap_eff) begin
               value_mem[s][fill[s]] = val;
               fill[s]++;
            end else if (s + 1 < used && fill[s + 1] < cap_eff) begin
               // The current stack is full, so the value spills onto the next one.
               s++;
               value_mem[s][fill[s]] = val;
               fill[s]++;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_POP: begin
            while (s > 0 && fill[s] == 0) s--;
            if (fill[s] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               fill[s]--;
               r.popped = value_mem[s][fill[s]];
            end
         end
         OP_POP_AT: begin
            if (idx >= used) begin
               r.status = ST_BADIDX;
            end else if (fill[idx] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               fill[idx]--;
               r.popped = value_mem[idx][fill[idx]];
            end
         end
         default: begin
         end
      endcase
      ptr_stack = s;
      r.cur     = s[INDEX_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      stack_result_type want;
      if (reset) begin
         foreach (fill[i]) fill[i] = 0;
         ptr_stack = 0;
         cap_cfg   = CAP_RESET;
         use_cfg   = USE_RESET;
         stack_results_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CAPACITY) cap_cfg = csr_wdata;
            else use_cfg = csr_wdata[USE_CFG_W-1:0];
            csr_taken++;
         end
         if (rsp_valid) begin
            if (stack_results_q.size() == 0) begin
               $display("%0t: response with none expected: status %0d value %0d stack %0d",
                        $time, rsp_status, $signed(rsp_popped_value), rsp_current_stack_out);
               fail_count++;
            end else begin
               want = stack_results_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_popped_value !== want.popped) begin
                  $display("%0t: popped value expected %0d actual %0d",
                           $time, $signed(want.popped), $signed(rsp_popped_value));
                  fail_count++;
               end
               if (rsp_current_stack_out !== want.cur) begin
                  $display("%0t: current stack expected %0d actual %0d",
                           $time, want.cur, rsp_current_stack_out);
                  fail_count++;
               end
            end
         end
         // A new request may be taken in the cycle that shows the previous
         // response, so the comparison above must come first.
         if (start && !busy) begin
            stack_results_q.push_back(predict_stack_op(req_opcode, req_push_value,
                                                       req_stack_index));
            reqs_taken++;
         end
      end
      pending = stack_results_q.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Set-of-stacks engine testbench
// Drives directed and random stack operations through several register
// settings with random idle gaps, and leaves the checking to the checker.
// -----------------------------------------------------------------------------
module tb_top
   import sos_pkg::*;
();

   localparam int ITEMS_PER_PHASE = 130;
   localparam int N_PHASES        = 7;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [VALUE_W-1:0]   req_push_value;
   logic [INDEX_W-1:0]   req_stack_index;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VALUE_W-1:0]   rsp_popped_value;
   logic [INDEX_W-1:0]   rsp_current_stack_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_index;
   logic [CAP_CFG_W-1:0] csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   reqs_taken;
   int                   csr_taken;

   // Capacity and stacks-in-use settings for the random phases.
   logic [CAP_CFG_W-1:0] cap_settings [N_PHASES] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3,
                                                     5'd10, 5'd7};
   logic [CAP_CFG_W-1:0] use_settings [N_PHASES] = '{5'd8, 5'd1, 5'd15, 5'd0, 5'h12,
                                                     5'd5, 5'h1E};

   always #5 clock = ~clock;

   set_of_stacks_engine_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_push_value        (req_push_value),
      .req_stack_index       (req_stack_index),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_popped_value      (rsp_popped_value),
      .rsp_current_stack_out (rsp_current_stack_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   set_of_stacks_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_push_value        (req_push_value),
      .req_stack_index       (req_stack_index),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_popped_value      (rsp_popped_value),
      .rsp_current_stack_out (rsp_current_stack_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .fail_count            (fail_count),
      .pending               (pending),
      .reqs_taken            (reqs_taken),
      .csr_taken             (csr_taken)
   );

   // Called at a falling edge; returns at the falling edge after the
   // transaction is taken, with start still high.
   task automatic issue_stack_op(input logic [OPCODE_W-1:0] op,
                                 input logic [VALUE_W-1:0]  val,
                                 input logic [INDEX_W-1:0]  idx);
      int taken_before;
      taken_before = reqs_taken;
      start           <= 1'b1;
      req_opcode      <= op;
      req_push_value  <= val;
      req_stack_index <= idx;
      do @(negedge clock); while (reqs_taken == taken_before);
   endtask

   task automatic write_csr(input logic idx, input logic [CAP_CFG_W-1:0] data);
      int taken_before;
      taken_before = csr_taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (csr_taken == taken_before);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 55) len = 0;
      else if (r < 90) len = $urandom_range(1, 3);
      else len = $urandom_range(4, 25);
      if (len > 0) begin
         start           <= 1'b0;
         req_opcode      <= OPCODE_W'($urandom);
         req_push_value  <= $urandom;
         req_stack_index <= INDEX_W'($urandom);
         repeat (len) @(negedge clock);
      end
   endtask

   // Drops start and lets every outstanding response arrive, then idles with start low.
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                  push_pct;
      int                  r;
      logic [OPCODE_W-1:0] op;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_NONE;
      req_push_value  = '0;
      req_stack_index = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_CAPACITY;
      csr_wdata       = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: two values per stack, three stacks in use.
      write_csr(CSR_CAPACITY, 5'd2);
      write_csr(CSR_IN_USE, 5'd3);
      issue_stack_op(OP_NONE, 32'hFFFF_FFFF, 3'd7);
      issue_stack_op(OP_POP, 32'd0, 3'd0);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd0);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd3);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd7);
      issue_stack_op(OP_PUSH, 32'h8000_0000, 3'd0);
      issue_stack_op(OP_PUSH, 32'h7FFF_FFFF, 3'd0);
      issue_stack_op(OP_PUSH, 32'h0000_0000, 3'd0);
      issue_stack_op(OP_PUSH, 32'hFFFF_FFFF, 3'd0);
      issue_stack_op(OP_PUSH, 32'h5A5A_5A5A, 3'd0);
      issue_stack_op(OP_PUSH, 32'hA5A5_A5A5, 3'd0);
      issue_stack_op(OP_PUSH, 32'h1234_5678, 3'd0);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd1);
      issue_stack_op(OP_POP, 32'd0, 3'd0);
      // The pointer sits on stack two, which the next write puts beyond the stacks in use.
      settle();
      write_csr(CSR_IN_USE, 5'd2);
      issue_stack_op(OP_PUSH, 32'h0BAD_0BAD, 3'd0);
      // Lowering the capacity leaves stack zero over-full.
      settle();
      write_csr(CSR_CAPACITY, 5'd1);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd1);
      issue_stack_op(OP_POP, 32'd0, 3'd0);
      issue_stack_op(OP_PUSH, 32'h0000_0007, 3'd0);
      issue_stack_op(OP_POP, 32'd0, 3'd0);
      issue_stack_op(OP_PUSH, 32'h0000_0001, 3'd0);
      issue_stack_op(OP_PUSH, 32'h0000_0002, 3'd0);
      issue_stack_op(OP_POP_AT, 32'd0, 3'd0);
      issue_stack_op(OP_POP, 32'd0, 3'd0);
      issue_stack_op(OP_POP, 32'd0, 3'd0);

      // Random phases, alternately filling and draining the bank.
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         write_csr(CSR_CAPACITY, cap_settings[p]);
         write_csr(CSR_IN_USE, use_settings[p]);
         push_pct = (p % 2 == 0) ? 70 : 40;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) op = OP_PUSH;
            else if (r < 95) op = ($urandom_range(0, 99) < 60) ? OP_POP : OP_POP_AT;
            else op = OP_NONE;
            issue_stack_op(op, random_value(), INDEX_W'($urandom_range(0, 7)));
            // Back-to-back stretch in the middle of every phase.
            if (i < 40 || i >= 70) idle_gap();
         end
      end
      settle();

      if (fail_count == 0 && pending == 0) begin
         $display("set_of_stacks_engine_top: match");
      end else begin
         $display("set_of_stacks_engine_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("set_of_stacks_engine_top: mismatch");
      $finish;
   end

endmodule

FILE: set_of_stacks_engine_top.f
design/sos_pkg.sv
design/sos_cnt_unit.sv
design/set_of_stacks_engine_top.sv
test/set_of_stacks_checker.sv
test/tb_top.sv
